>>> rtl/core/bhu_pkg.sv
// Shared types and constants of the bilinear heightmap upscaler.
`default_nettype none

package bhu_pkg;

  // Field widths of the request and result items.
  localparam int unsigned ROW_W      = 8;
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned HEIGHT_W   = 16;
  localparam int unsigned RESULT_W   = 24;

  // Configuration register widths.
  localparam int unsigned HSCALE_W   = 7;
  localparam int unsigned VSCALE_W   = 8;
  localparam int unsigned SIDE_W     = 9;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;

  // Largest horizontal scale and the width of its square.
  localparam int unsigned HSCALE_MAX = 64;
  localparam int unsigned SQ_W       = 13;

  // Depth of the result queue at the output.
  localparam int unsigned RES_FIFO_DEPTH = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE_H     = 2'd0,
    CFG_SCALE_V     = 2'd1,
    CFG_SOURCE_SIDE = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef struct packed {
    logic                operation;
    logic [ROW_W-1:0]    sample_row;
    logic [ROW_W-1:0]    sample_col;
    logic [HEIGHT_W-1:0] sample_height;
    logic [COORD_W-1:0]  query_x;
    logic [COORD_W-1:0]  query_z;
  } req_t;

  typedef struct packed {
    logic                result_kind;
    logic [RESULT_W-1:0] interpolated_height;
  } res_t;

  // What a request carries alongside its coordinates through the divider.
  typedef struct packed {
    op_e                 op;
    logic [ROW_W-1:0]    row;
    logic [ROW_W-1:0]    col;
    logic [HEIGHT_W-1:0] height;
  } item_tag_t;

endpackage

`default_nettype wire

>>> rtl/core/bhu_if.sv
// Request and result stream interfaces of the bilinear heightmap upscaler.
`default_nettype none

interface bhu_req_if;
  import bhu_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bhu_res_if;
  import bhu_pkg::*;

  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/bhu_div.sv
// Pipelined restoring divider with a common divisor and a tag carried alongside.
`default_nettype none

module bhu_div #(
  parameter int unsigned LANES = 1,
  parameter int unsigned QW    = 12,
  parameter int unsigned DW    = 7,
  parameter int unsigned STEPS = 4,
  parameter int unsigned TW    = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [DW-1:0]               den_i,
  input  logic [LANES-1:0][QW-1:0]    quo_i,
  input  logic [LANES-1:0][DW-1:0]    rem_i,
  input  logic [TW-1:0]               tag_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [LANES-1:0][QW-1:0]    quo_o,
  output logic [LANES-1:0][DW-1:0]    rem_o,
  output logic [TW-1:0]               tag_o
);

  localparam int unsigned NST = QW / STEPS;

  // STEPS quotient bits per stage; the remainder must start below the divisor.
  function automatic logic [DW+QW-1:0] div_steps(input logic [DW-1:0] rem,
                                                 input logic [QW-1:0] quo,
                                                 input logic [DW-1:0] den);
    logic [DW:0]   trial;
    logic [DW-1:0] r;
    logic [QW-1:0] q;
    r = rem;
    q = quo;
    for (int i = 0; i < int'(STEPS); i++) begin
      trial = {r, q[QW-1]};
      q     = {q[QW-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        trial = trial - {1'b0, den};
        q[0]  = 1'b1;
      end
      r = trial[DW-1:0];
    end
    return {r, q};
  endfunction

  logic                     v_q   [NST];
  logic [LANES-1:0][QW-1:0] quo_q [NST];
  logic [LANES-1:0][DW-1:0] rem_q [NST];
  logic [DW-1:0]            den_q [NST];
  logic [TW-1:0]            tag_q [NST];
  logic [NST:0]             rdy;

  always_comb begin
    rdy[NST] = out_ready_i;
    for (int k = int'(NST) - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  for (genvar k = 0; k < NST; k++) begin : g_st
    logic                     sv;
    logic [LANES-1:0][QW-1:0] sq;
    logic [LANES-1:0][DW-1:0] sr;
    logic [DW-1:0]            sd;
    logic [TW-1:0]            st;

    if (k == 0) begin : g_head
      assign sv = in_valid_i;
      assign sq = quo_i;
      assign sr = rem_i;
      assign sd = den_i;
      assign st = tag_i;
    end else begin : g_body
      assign sv = v_q[k-1];
      assign sq = quo_q[k-1];
      assign sr = rem_q[k-1];
      assign sd = den_q[k-1];
      assign st = tag_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= sv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && sv) begin
        for (int l = 0; l < int'(LANES); l++) begin
          {rem_q[k][l], quo_q[k][l]} <= div_steps(sr[l], sq[l], sd);
        end
        den_q[k] <= sd;
        tag_q[k] <= st;
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NST-1];
  assign quo_o       = quo_q[NST-1];
  assign rem_o       = rem_q[NST-1];
  assign tag_o       = tag_q[NST-1];

endmodule

`default_nettype wire

>>> rtl/core/bilinear_heightmap_upscaler.sv
// Bilinear heightmap upscaler: sample store, corner sequencer and blend pipeline.
// Loads and queries pass the coordinate divider, clamp stage, corner sequencer, blend
// pipeline and final divider in request order. Throughput: one load per cycle unless the
// credits or the final divider hold it; a query holds the sequencer for four corner reads.
// Reset clears all control state and sets the scales to 1 and the side to 256; the
// sample memory is not cleared and holds undefined data until it is loaded.
`default_nettype none

module bilinear_heightmap_upscaler #(
  parameter int unsigned SOURCE_SIDE_MAX = 256,
  parameter int unsigned OUTPUT_SIDE_MAX = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bhu_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bhu_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  bhu_req_if.sink                         request_i,
  bhu_res_if.source                       result_o
);

  import bhu_pkg::*;

  // Address bits per axis of the sample memory; a row and a column form the address.
  localparam int unsigned AW          = $clog2(SOURCE_SIDE_MAX);
  localparam int unsigned STORE_DEPTH = 1 << (2 * AW);

  // The side register can not exceed its own range, nor the memory's side.
  localparam int unsigned SIDE_REG_MAX = (1 << SIDE_W) - 1;
  localparam int unsigned SIDE_CAP     =
      (SOURCE_SIDE_MAX < SIDE_REG_MAX) ? SOURCE_SIDE_MAX : SIDE_REG_MAX;
  localparam int unsigned SIDE_RST     = 256;
  localparam int unsigned LAST_RST     = ((SIDE_RST < SIDE_CAP) ? SIDE_RST : SIDE_CAP) - 1;

  // Largest query coordinate after saturation.
  localparam int unsigned COORD_MAX = (1 << COORD_W) - 1;
  localparam int unsigned QMAX_INT  =
      (OUTPUT_SIDE_MAX - 1 < COORD_MAX) ? OUTPUT_SIDE_MAX - 1 : COORD_MAX;
  localparam logic [COORD_W-1:0] QMAX = COORD_W'(QMAX_INT);

  // Arithmetic widths of the blend. A pair blend a = h0*(s-r) + h1*r is at most
  // 65535*64, the cross blend at most 65535*4096 and the scaled numerator below 2^36.
  localparam int unsigned PROD_W = HEIGHT_W + HSCALE_W;
  localparam int unsigned A_W    = HEIGHT_W + 6;
  localparam int unsigned AX_W   = A_W + HSCALE_W;
  localparam int unsigned SUM_W  = HEIGHT_W + 12;
  localparam int unsigned NUM_W  = SUM_W + VSCALE_W;

  localparam int unsigned FAW = $clog2(RES_FIFO_DEPTH);
  localparam int unsigned FCW = FAW + 1;

  // --------------------------------------------------------------------------
  // Configuration registers and the values derived from them. The user must only change
  // configuration while the block is idle; the block does not enforce it. The derived copies
  // then settle long before the next request reaches the logic that uses them.
  // --------------------------------------------------------------------------
  logic [HSCALE_W-1:0] scale_h_q;
  logic [VSCALE_W-1:0] scale_v_q;
  logic [SIDE_W-1:0]   side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_h_q <= HSCALE_W'(1);
      scale_v_q <= VSCALE_W'(1);
      side_q    <= SIDE_W'(SIDE_RST);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SCALE_H:     scale_h_q <= cfg_data_i[HSCALE_W-1:0];
        CFG_SCALE_V:     scale_v_q <= cfg_data_i[VSCALE_W-1:0];
        CFG_SOURCE_SIDE: side_q    <= cfg_data_i[SIDE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  logic [HSCALE_W-1:0] eff_s_d, eff_s_q;
  logic [SIDE_W-1:0]   side_eff;
  logic [SIDE_W-1:0]   last_d, last_q;
  logic [SQ_W-1:0]     den_d, den_q;

  // A horizontal scale of zero acts as one, larger scales saturate at the maximum.
  // The side in use is kept between two and the memory's side.
  always_comb begin
    if (scale_h_q == '0) begin
      eff_s_d = HSCALE_W'(1);
    end else if (scale_h_q > HSCALE_W'(HSCALE_MAX)) begin
      eff_s_d = HSCALE_W'(HSCALE_MAX);
    end else begin
      eff_s_d = scale_h_q;
    end
    if (side_q < SIDE_W'(2)) begin
      side_eff = SIDE_W'(2);
    end else if (side_q > SIDE_W'(SIDE_CAP)) begin
      side_eff = SIDE_W'(SIDE_CAP);
    end else begin
      side_eff = side_q;
    end
    last_d = side_eff - SIDE_W'(1);
    den_d  = SQ_W'(eff_s_d) * SQ_W'(eff_s_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_s_q <= HSCALE_W'(1);
      last_q  <= SIDE_W'(LAST_RST);
      den_q   <= SQ_W'(1);
    end else begin
      eff_s_q <= eff_s_d;
      last_q  <= last_d;
      den_q   <= den_d;
    end
  end

  // --------------------------------------------------------------------------
  // Front divider: both query coordinates are split into a source cell and a
  // blend weight by the horizontal scale. Loads travel along as a tag so that
  // loads and queries reach the sample memory in request order.
  // --------------------------------------------------------------------------
  logic [COORD_W-1:0]                 qx_sat, qz_sat;
  logic [1:0][COORD_W-1:0]            fdiv_quo_in;
  logic [1:0][HSCALE_W-1:0]           fdiv_rem_in;
  item_tag_t                          fdiv_tag_in;
  logic                               fdiv_out_valid, fdiv_out_ready;
  logic [1:0][COORD_W-1:0]            fdiv_quo;
  logic [1:0][HSCALE_W-1:0]           fdiv_rem;
  logic [$bits(item_tag_t)-1:0]       fdiv_tag;

  assign qx_sat = (request_i.data.query_x > QMAX) ? QMAX : request_i.data.query_x;
  assign qz_sat = (request_i.data.query_z > QMAX) ? QMAX : request_i.data.query_z;

  assign fdiv_quo_in = {qz_sat, qx_sat};
  assign fdiv_rem_in = '0;
  assign fdiv_tag_in = '{op:     op_e'(request_i.data.operation),
                         row:    request_i.data.sample_row,
                         col:    request_i.data.sample_col,
                         height: request_i.data.sample_height};

  bhu_div #(
    .LANES (2),
    .QW    (COORD_W),
    .DW    (HSCALE_W),
    .STEPS (4),
    .TW    ($bits(item_tag_t))
  ) u_coord_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (request_i.valid),
    .in_ready_o  (request_i.ready),
    .den_i       (eff_s_q),
    .quo_i       (fdiv_quo_in),
    .rem_i       (fdiv_rem_in),
    .tag_i       (fdiv_tag_in),
    .out_valid_o (fdiv_out_valid),
    .out_ready_i (fdiv_out_ready),
    .quo_o       (fdiv_quo),
    .rem_o       (fdiv_rem),
    .tag_o       (fdiv_tag)
  );

  // --------------------------------------------------------------------------
  // Clamp stage: the cell and its far neighbor are held inside the map, and
  // the four blend weights are formed from the remainders.
  // --------------------------------------------------------------------------
  logic [COORD_W-1:0]  last_ext;
  logic [COORD_W:0]    ix1, iz1;
  logic [COORD_W-1:0]  x0_w, x1_w, z0_w, z1_w;

  logic                c_valid_q;
  item_tag_t           c_tag_q;
  logic [AW-1:0]       c_x0_q, c_x1_q, c_z0_q, c_z1_q;
  logic [HSCALE_W-1:0] c_wx0_q, c_wx1_q, c_wz0_q, c_wz1_q;
  logic                c_take;

  assign last_ext = COORD_W'(last_q);
  assign ix1      = {1'b0, fdiv_quo[0]} + (COORD_W+1)'(1);
  assign iz1      = {1'b0, fdiv_quo[1]} + (COORD_W+1)'(1);
  assign x0_w     = (fdiv_quo[0] > last_ext) ? last_ext : fdiv_quo[0];
  assign z0_w     = (fdiv_quo[1] > last_ext) ? last_ext : fdiv_quo[1];
  assign x1_w     = (ix1 > {1'b0, last_ext}) ? last_ext : ix1[COORD_W-1:0];
  assign z1_w     = (iz1 > {1'b0, last_ext}) ? last_ext : iz1[COORD_W-1:0];

  assign fdiv_out_ready = !c_valid_q || c_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (fdiv_out_ready) begin
      c_valid_q <= fdiv_out_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fdiv_out_ready && fdiv_out_valid) begin
      c_tag_q <= item_tag_t'(fdiv_tag);
      c_x0_q  <= AW'(x0_w);
      c_x1_q  <= AW'(x1_w);
      c_z0_q  <= AW'(z0_w);
      c_z1_q  <= AW'(z1_w);
      c_wx0_q <= eff_s_q - fdiv_rem[0];
      c_wx1_q <= fdiv_rem[0];
      c_wz0_q <= eff_s_q - fdiv_rem[1];
      c_wz1_q <= fdiv_rem[1];
    end
  end

  // --------------------------------------------------------------------------
  // Corner sequencer. A load writes the memory in a single step; a query reads its
  // corners one after another in the order (x0,z0), (x0,z1), (x1,z0), (x1,z1).
  // Everything after the memory runs without stalls, so an item only starts
  // when it holds a credit for a slot in the result queue. A credit is taken
  // when an item starts and returned when its result leaves the block.
  // --------------------------------------------------------------------------
  logic                q_valid_q;
  item_tag_t           q_tag_q;
  logic [AW-1:0]       q_x0_q, q_x1_q, q_z0_q, q_z1_q;
  logic [HSCALE_W-1:0] q_wx0_q, q_wx1_q, q_wz0_q, q_wz1_q;
  logic [1:0]          q_cnt_q;
  logic                q_first, q_last, q_step, q_done, q_accept;
  logic                space_ok, rdiv_in_ready;
  logic [FCW-1:0]      credit_q;
  logic                res_pop;

  assign q_first  = (q_cnt_q == 2'd0);
  assign q_last   = (q_tag_q.op == OP_LOAD) || (q_cnt_q == 2'd3);
  assign space_ok = (credit_q < FCW'(RES_FIFO_DEPTH)) && rdiv_in_ready;
  assign q_step   = q_valid_q && (!q_first || space_ok);
  assign q_done   = q_step && q_last;
  assign q_accept = c_valid_q && (!q_valid_q || q_done);
  assign c_take   = q_accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_valid_q <= 1'b0;
      q_cnt_q   <= 2'd0;
    end else begin
      if (q_accept) begin
        q_valid_q <= 1'b1;
      end else if (q_done) begin
        q_valid_q <= 1'b0;
      end
      if (q_step) begin
        q_cnt_q <= q_last ? 2'd0 : q_cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_accept) begin
      q_tag_q <= c_tag_q;
      q_x0_q  <= c_x0_q;
      q_x1_q  <= c_x1_q;
      q_z0_q  <= c_z0_q;
      q_z1_q  <= c_z1_q;
      q_wx0_q <= c_wx0_q;
      q_wx1_q <= c_wx1_q;
      q_wz0_q <= c_wz0_q;
      q_wz1_q <= c_wz1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
    end else begin
      case ({q_step && q_first, res_pop})
        2'b10:   credit_q <= credit_q + FCW'(1);
        2'b01:   credit_q <= credit_q - FCW'(1);
        default: credit_q <= credit_q;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sample memory: one write or one read per cycle, read data registered.
  // A load outside the memory's side is acknowledged but not stored.
  // --------------------------------------------------------------------------
  logic [HEIGHT_W-1:0] store_q [STORE_DEPTH];
  logic [HEIGHT_W-1:0] rd_q;
  logic                load_in_range, mem_we, mem_re;
  logic [2*AW-1:0]     waddr, raddr;

  assign load_in_range = (32'(q_tag_q.row) < 32'(SOURCE_SIDE_MAX)) &&
                         (32'(q_tag_q.col) < 32'(SOURCE_SIDE_MAX));
  assign mem_we = q_step && (q_tag_q.op == OP_LOAD) && load_in_range;
  assign mem_re = q_step && (q_tag_q.op == OP_QUERY);
  assign waddr  = {AW'(q_tag_q.row), AW'(q_tag_q.col)};
  assign raddr  = {(q_cnt_q[1] ? q_x1_q : q_x0_q), (q_cnt_q[0] ? q_z1_q : q_z0_q)};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[waddr] <= q_tag_q.height;
    end
    if (mem_re) begin
      rd_q <= store_q[raddr];
    end
  end

  // --------------------------------------------------------------------------
  // Blend pipeline. Each corner is weighted along the second axis as it comes
  // out of the memory; the two pair sums are then weighted along the first
  // axis, added and multiplied by the vertical scale.
  // --------------------------------------------------------------------------
  logic                r_valid_q;
  op_e                 r_op_q;
  logic [1:0]          r_cnt_q;
  logic [HSCALE_W-1:0] r_wz_q, r_wx0_q, r_wx1_q;
  logic                r_last;
  logic [PROD_W-1:0]   prod;
  logic [A_W-1:0]      prod_a;
  logic [A_W-1:0]      acc_a_q, acc_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
    end else begin
      r_valid_q <= q_step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_step) begin
      r_op_q  <= q_tag_q.op;
      r_cnt_q <= q_cnt_q;
      r_wz_q  <= q_cnt_q[0] ? q_wz1_q : q_wz0_q;
      r_wx0_q <= q_wx0_q;
      r_wx1_q <= q_wx1_q;
    end
  end

  assign r_last = (r_op_q == OP_LOAD) || (r_cnt_q == 2'd3);
  assign prod   = PROD_W'(rd_q) * PROD_W'(r_wz_q);
  assign prod_a = prod[A_W-1:0];

  always_ff @(posedge clk_i) begin
    if (r_valid_q && (r_op_q == OP_QUERY)) begin
      case (r_cnt_q)
        2'd0:    acc_a_q <= prod_a;
        2'd1:    acc_a_q <= acc_a_q + prod_a;
        2'd2:    acc_b_q <= prod_a;
        default: begin
        end
      endcase
    end
  end

  logic                m_valid_q;
  op_e                 m_op_q;
  logic [A_W-1:0]      m_a_q, m_b_q;
  logic [HSCALE_W-1:0] m_wx0_q, m_wx1_q;

  logic                n_valid_q;
  op_e                 n_op_q;
  logic [AX_W-1:0]     n_ax_q, n_bx_q;

  logic                o_valid_q;
  op_e                 o_op_q;
  logic [SUM_W-1:0]    o_sum_q;

  logic                p_valid_q;
  op_e                 p_op_q;
  logic [NUM_W-1:0]    p_num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      n_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
      p_valid_q <= 1'b0;
    end else begin
      m_valid_q <= r_valid_q && r_last;
      n_valid_q <= m_valid_q;
      o_valid_q <= n_valid_q;
      p_valid_q <= o_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m_op_q  <= r_op_q;
    m_a_q   <= acc_a_q;
    m_b_q   <= acc_b_q + prod_a;
    m_wx0_q <= r_wx0_q;
    m_wx1_q <= r_wx1_q;

    n_op_q  <= m_op_q;
    n_ax_q  <= AX_W'(m_a_q) * AX_W'(m_wx0_q);
    n_bx_q  <= AX_W'(m_b_q) * AX_W'(m_wx1_q);

    o_op_q  <= n_op_q;
    o_sum_q <= SUM_W'(n_ax_q + n_bx_q);

    p_op_q  <= o_op_q;
    p_num_q <= NUM_W'(o_sum_q) * NUM_W'(scale_v_q);
  end

  // --------------------------------------------------------------------------
  // Final divide by the square of the horizontal scale. The quotient always
  // fits the result field, so the bits above it already lie below the divisor
  // and start the remainder; only the low bits are shifted through.
  // --------------------------------------------------------------------------
  logic [0:0][RESULT_W-1:0] rdiv_quo_in, rdiv_quo;
  logic [0:0][SQ_W-1:0]     rdiv_rem_in;
  logic                     rdiv_out_valid, rdiv_out_ready;
  logic [0:0]               rdiv_tag;
  logic                     fifo_full;

  assign rdiv_quo_in[0] = p_num_q[RESULT_W-1:0];
  assign rdiv_rem_in[0] = SQ_W'(p_num_q[NUM_W-1:RESULT_W]);
  assign rdiv_out_ready = !fifo_full;

  bhu_div #(
    .LANES (1),
    .QW    (RESULT_W),
    .DW    (SQ_W),
    .STEPS (4),
    .TW    (1)
  ) u_norm_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (p_valid_q),
    .in_ready_o  (rdiv_in_ready),
    .den_i       (den_q),
    .quo_i       (rdiv_quo_in),
    .rem_i       (rdiv_rem_in),
    .tag_i       (p_op_q),
    .out_valid_o (rdiv_out_valid),
    .out_ready_i (rdiv_out_ready),
    .quo_o       (rdiv_quo),
    .rem_o       (),
    .tag_o       (rdiv_tag)
  );

  // --------------------------------------------------------------------------
  // Result queue. The credits guarantee a free slot for every item in flight,
  // so the blend pipeline never has to wait; the queue also parts the output
  // handshake from the rest of the block. A load acknowledgment reads zero.
  // --------------------------------------------------------------------------
  res_t           fifo_q [RES_FIFO_DEPTH];
  logic [FAW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FCW-1:0] fifo_cnt_q;
  logic           res_push;
  res_t           push_data;

  assign fifo_full = (fifo_cnt_q == FCW'(RES_FIFO_DEPTH));
  assign res_push  = rdiv_out_valid && !fifo_full;
  assign res_pop   = result_o.valid && result_o.ready;

  assign push_data.result_kind         = rdiv_tag[0];
  assign push_data.interpolated_height =
      (op_e'(rdiv_tag[0]) == OP_QUERY) ? rdiv_quo[0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (res_push) begin
        wr_ptr_q <= wr_ptr_q + FAW'(1);
      end
      if (res_pop) begin
        rd_ptr_q <= rd_ptr_q + FAW'(1);
      end
      case ({res_push, res_pop})
        2'b10:   fifo_cnt_q <= fifo_cnt_q + FCW'(1);
        2'b01:   fifo_cnt_q <= fifo_cnt_q - FCW'(1);
        default: fifo_cnt_q <= fifo_cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      fifo_q[wr_ptr_q] <= push_data;
    end
  end

  assign result_o.valid = (fifo_cnt_q != '0);
  assign result_o.data  = fifo_q[rd_ptr_q];

endmodule

`default_nettype wire

>>> test/bilinear_heightmap_upscaler_test.sv
// Self-checking testbench of the bilinear heightmap upscaler, with a predictor and random traffic.
`timescale 1ns / 100ps

module bilinear_heightmap_upscaler_test;
  import bhu_pkg::*;

  // The source map is 256 x 256 samples and output coordinates are 12 bits wide.
  localparam int unsigned SIDE_MAX  = 256;
  localparam int unsigned COORD_MAX = (1 << COORD_W) - 1;

  // Index 3 is not mapped to any register; a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  // Random phases, each with its own register setting, and requests per phase.
  localparam int PHASES          = 13;
  localparam int ITEMS_PER_PHASE = 55;

  // The quiet stretch at the end leaves room for any stray result, and the watchdog
  // limit covers the long output stall below with a wide margin.
  localparam int DRAIN_CYCLES  = 40;
  localparam int LONG_HOLD     = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  bhu_req_if req_if ();
  bhu_res_if res_if ();

  bilinear_heightmap_upscaler #(
    .SOURCE_SIDE_MAX(SIDE_MAX),
    .OUTPUT_SIDE_MAX(COORD_MAX + 1)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .request_i (req_if),
    .result_o  (res_if)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: the register copies, the sample store and a map of which
  // store entries have been written since reset. Queries are only issued when
  // all four corners they read have been loaded.
  // ---------------------------------------------------------------------------
  logic [HSCALE_W-1:0] hscale_cfg;
  logic [VSCALE_W-1:0] vscale_cfg;
  logic [SIDE_W-1:0]   side_cfg;
  logic [HEIGHT_W-1:0] height_store [SIDE_MAX*SIDE_MAX];
  bit                  sample_written [SIDE_MAX*SIDE_MAX];

  // Heights the block still owes us, oldest first.
  res_t awaited_results [$];

  // The block of source cells that the current phase has loaded; random queries
  // mostly aim inside it so that large maps can be exercised without a full load.
  int unsigned win_row, win_col, win_span;

  bit idle_on;
  bit hold_off_pending;
  int mismatch_count;
  int n_loads, n_queries, n_settings;

  function automatic int unsigned eff_hscale();
    if (hscale_cfg == 0) return 1;
    if (hscale_cfg > HSCALE_MAX) return HSCALE_MAX;
    return hscale_cfg;
  endfunction

  function automatic int unsigned eff_side();
    if (side_cfg < 2) return 2;
    if (side_cfg > SIDE_MAX) return SIDE_MAX;
    return side_cfg;
  endfunction

  function automatic int unsigned cell_index(int unsigned row, int unsigned col);
    return row * SIDE_MAX + col;
  endfunction

  // Splits one output coordinate into the two source cells it blends between,
  // both held to the last index of the map in use, and the blend weight.
  function automatic void split_coord(input logic [COORD_W-1:0] q,
                                      output int unsigned lo, output int unsigned hi,
                                      output int unsigned rem);
    int unsigned s, last, cell_i;
    s      = eff_hscale();
    last   = eff_side() - 1;
    cell_i = q / s;
    rem    = q % s;
    lo     = (cell_i > last) ? last : cell_i;
    hi     = (cell_i + 1 > last) ? last : cell_i + 1;
  endfunction

  function automatic bit corners_loaded(logic [COORD_W-1:0] qx, logic [COORD_W-1:0] qz);
    int unsigned x0, x1, z0, z1, rx, rz;
    split_coord(qx, x0, x1, rx);
    split_coord(qz, z0, z1, rz);
    return sample_written[cell_index(x0, z0)] && sample_written[cell_index(x0, z1)] &&
           sample_written[cell_index(x1, z0)] && sample_written[cell_index(x1, z1)];
  endfunction

  // Works out the result of one request and applies a load to the store copy.
  function automatic res_t predict_result(req_t r);
    res_t            res;
    int unsigned     s, x0, x1, z0, z1, rx, rz;
    longint unsigned near_row, far_row, num;
    res.result_kind         = r.operation;
    res.interpolated_height = '0;
    if (r.operation == OP_LOAD) begin
      // Row and column are 8 bits, so every load lands inside the store.
      height_store[cell_index(r.sample_row, r.sample_col)]   = r.sample_height;
      sample_written[cell_index(r.sample_row, r.sample_col)] = 1'b1;
    end else begin
      s = eff_hscale();
      split_coord(r.query_x, x0, x1, rx);
      split_coord(r.query_z, z0, z1, rz);
      near_row = longint'(height_store[cell_index(x0, z0)]) * (s - rz) +
                 longint'(height_store[cell_index(x0, z1)]) * rz;
      far_row  = longint'(height_store[cell_index(x1, z0)]) * (s - rz) +
                 longint'(height_store[cell_index(x1, z1)]) * rz;
      num      = (near_row * (s - rx) + far_row * rx) * vscale_cfg;
      res.interpolated_height = RESULT_W'(num / (s * s));
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed stimulus: a list of rows, each a request or a register write.
  // Where the answer is obvious it is typed in; the rest goes to the predictor.
  // ---------------------------------------------------------------------------
  typedef enum {ROW_REQUEST, ROW_CONFIG} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    req_t                  req;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    bit                    typed;
    res_t                  want;
  } script_row_t;

  script_row_t script [$];

  function automatic script_row_t load_row(int row, int col, int h);
    script_row_t sr;
    sr.kind                     = ROW_REQUEST;
    sr.req                      = '0;
    sr.req.operation            = OP_LOAD;
    sr.req.sample_row           = row;
    sr.req.sample_col           = col;
    sr.req.sample_height        = h;
    sr.idx                      = '0;
    sr.val                      = '0;
    // A load is always acknowledged with a zero height.
    sr.typed                    = 1'b1;
    sr.want.result_kind         = OP_LOAD;
    sr.want.interpolated_height = '0;
    return sr;
  endfunction

  function automatic script_row_t query_row(int x, int z, bit typed, int h);
    script_row_t sr;
    sr.kind                     = ROW_REQUEST;
    sr.req                      = '0;
    sr.req.operation            = OP_QUERY;
    sr.req.query_x              = x;
    sr.req.query_z              = z;
    sr.idx                      = '0;
    sr.val                      = '0;
    sr.typed                    = typed;
    sr.want.result_kind         = OP_QUERY;
    sr.want.interpolated_height = h;
    return sr;
  endfunction

  function automatic script_row_t config_row(logic [CFG_IDX_W-1:0] idx,
                                             logic [CFG_DATA_W-1:0] val);
    script_row_t sr;
    sr.kind  = ROW_CONFIG;
    sr.req   = '0;
    sr.idx   = idx;
    sr.val   = val;
    sr.typed = 1'b0;
    sr.want  = '0;
    return sr;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset and the known starting values of every input.
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = '0;
    cfg_data    = '0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Request side. Inputs change on the falling edge; a request is taken on the
  // rising edge where valid and ready are both high. Valid stays high from one
  // request to the next unless an idle burst is drawn or the results are drained.
  // ---------------------------------------------------------------------------
  task automatic send_request(req_t r, bit typed, res_t want);
    res_t predicted;
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      req_if.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    req_if.valid = 1'b1;
    req_if.data  = r;
    do @(posedge clk_i); while (!req_if.ready);
    predicted = predict_result(r);
    awaited_results.push_back(typed ? want : predicted);
    if (r.operation == OP_LOAD) n_loads++;
    else n_queries++;
  endtask

  // Stops offering requests and waits for every outstanding result.
  task automatic wait_drained();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  // Register writes happen only while the block is idle; the copy in the
  // predictor is updated with the same width masking as the hardware.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = val;
    @(posedge clk_i);
    case (idx)
      CFG_SCALE_H:     hscale_cfg = val[HSCALE_W-1:0];
      CFG_SCALE_V:     vscale_cfg = val[VSCALE_W-1:0];
      CFG_SOURCE_SIDE: side_cfg   = val[SIDE_W-1:0];
      default: ;  // unmapped index, the write is dropped
    endcase
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  // Picks query coordinates whose four corners have all been loaded. Fully
  // random coordinates alternate with ones aimed at the loaded window; if
  // nothing fits the caller sends a load instead.
  function automatic bit pick_query(output logic [COORD_W-1:0] qx,
                                    output logic [COORD_W-1:0] qz);
    int unsigned s, ix, iz;
    s = eff_hscale();
    for (int t = 0; t < 40; t++) begin
      if (t % 2 == 0) begin
        qx = $urandom;
        qz = $urandom;
      end else begin
        ix = win_row * s + $urandom_range(0, win_span * s - 1);
        iz = win_col * s + $urandom_range(0, win_span * s - 1);
        qx = (ix > COORD_MAX) ? COORD_MAX : ix;
        qz = (iz > COORD_MAX) ? COORD_MAX : iz;
      end
      if (corners_loaded(qx, qz)) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic req_t random_request();
    req_t                r;
    logic [COORD_W-1:0]  qx, qz;
    bit                  found;
    r.operation     = OP_LOAD;
    r.sample_row    = $urandom;
    r.sample_col    = $urandom;
    r.sample_height = $urandom;
    r.query_x       = $urandom;
    r.query_z       = $urandom;
    found = 1'b0;
    if ($urandom_range(0, 9) < 7) found = pick_query(qx, qz);
    if (found) begin
      r.operation = OP_QUERY;
      r.query_x   = qx;
      r.query_z   = qz;
    end else if ($urandom_range(0, 1) == 1) begin
      // Refresh a sample that queries of this phase actually read.
      r.sample_row = win_row + $urandom_range(0, win_span - 1);
      r.sample_col = win_col + $urandom_range(0, win_span - 1);
    end
    return r;
  endfunction

  // Loads the window that this phase's queries will read. Small maps are
  // loaded whole; on large ones a 4 x 4 block within reach of the coordinates
  // is placed at random.
  task automatic load_window();
    int unsigned s, last, reach;
    req_t        r;
    s    = eff_hscale();
    last = eff_side() - 1;
    if (last < 16) begin
      win_row  = 0;
      win_col  = 0;
      win_span = last + 1;
    end else begin
      reach    = (COORD_MAX / s < last) ? COORD_MAX / s : last;
      win_span = 4;
      win_row  = $urandom_range(0, reach);
      win_col  = $urandom_range(0, reach);
      if (win_row + win_span - 1 > last) win_row = last - win_span + 1;
      if (win_col + win_span - 1 > last) win_col = last - win_span + 1;
    end
    for (int i = 0; i < win_span; i++) begin
      for (int j = 0; j < win_span; j++) begin
        r               = random_request();
        r.operation     = OP_LOAD;
        r.sample_row    = win_row + i;
        r.sample_col    = win_col + j;
        send_request(r, 1'b0, '0);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side. Ready drops in random bursts while idling is on, and once for
  // a long stretch so that the result queue fills and the input backs up.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall_left;
    stall_left   = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_pending) begin
        stall_left       = LONG_HOLD;
        hold_off_pending = 1'b0;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 6);
      end
      if (stall_left > 0) begin
        res_if.ready = 1'b0;
        stall_left--;
      end else begin
        res_if.ready = 1'b1;
      end
    end
  end

  // Every accepted result is compared with the oldest outstanding one.
  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (awaited_results.size() == 0) begin
        $error("result with nothing outstanding: result_kind %0d interpolated_height %0d",
               res_if.data.result_kind, res_if.data.interpolated_height);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        if (res_if.data.result_kind !== want.result_kind) begin
          $error("result_kind: expected %0d, got %0d",
                 want.result_kind, res_if.data.result_kind);
          mismatch_count++;
        end
        if (res_if.data.interpolated_height !== want.interpolated_height) begin
          $error("interpolated_height: expected %0d, got %0d",
                 want.interpolated_height, res_if.data.interpolated_height);
          mismatch_count++;
        end
      end
    end
  end

  // The watchdog ends a run in which nothing moves on either side for too long.
  always @(posedge clk_i) begin : watchdog
    int quiet_cycles;
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timed out with %0d results outstanding.", awaited_results.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [CFG_DATA_W-1:0] h_val, v_val, side_val;
    mismatch_count   = 0;
    n_loads          = 0;
    n_queries        = 0;
    n_settings       = 1;
    hold_off_pending = 1'b0;
    idle_on          = 1'b1;
    hscale_cfg       = 1;
    vscale_cfg       = 1;
    side_cfg         = SIDE_MAX;
    win_row          = 0;
    win_col          = 0;
    win_span         = 2;

    // Reset values first: unit scales on the full 256 map. Loads at both
    // corners of the store, then queries whose answers are the samples
    // themselves, including one past the far edge that clamps to the last cell.
    script.push_back(load_row(0, 0, 'hFFFF));
    script.push_back(load_row(0, 1, 'h0000));
    script.push_back(load_row(1, 0, 'h8000));
    script.push_back(load_row(1, 1, 'h0001));
    script.push_back(load_row(255, 255, 'h1234));
    script.push_back(load_row(255, 254, 'h00FF));
    script.push_back(load_row(254, 255, 'hFF00));
    script.push_back(load_row(254, 254, 'h7FFF));
    script.push_back(query_row(0, 0, 1'b1, 'hFFFF));
    script.push_back(query_row(COORD_MAX, COORD_MAX, 1'b1, 'h1234));
    script.push_back(query_row(254, 255, 1'b1, 'hFF00));
    script.push_back(query_row(255, 254, 1'b1, 'h00FF));
    // Scale 3 on a 2 x 2 map at the largest height multiplier: the full-height
    // corner times 255, then blended points and a clamped far coordinate.
    script.push_back(config_row(CFG_SCALE_H, 3));
    script.push_back(config_row(CFG_SCALE_V, 255));
    script.push_back(config_row(CFG_SOURCE_SIDE, 2));
    script.push_back(query_row(0, 0, 1'b1, 'hFFFF * 255));
    script.push_back(query_row(2, 4, 1'b0, 0));
    script.push_back(query_row(COORD_MAX, 0, 1'b0, 0));
    // A zero height multiplier gives zero whatever the samples are.
    script.push_back(config_row(CFG_SCALE_V, 0));
    script.push_back(query_row(5, 5, 1'b1, 0));
    // All-ones writes: the horizontal scale saturates at 64, a side of zero
    // acts as 2, and a write to the unmapped index is dropped.
    script.push_back(config_row(CFG_SCALE_H, '1));
    script.push_back(config_row(CFG_SCALE_V, '1));
    script.push_back(config_row(CFG_SOURCE_SIDE, 0));
    script.push_back(query_row(63, 63, 1'b0, 0));
    script.push_back(query_row(32, 0, 1'b0, 0));
    script.push_back(config_row(CFG_UNMAPPED, '1));
    script.push_back(query_row(1, 2, 1'b0, 0));
    // Scale just above the top saturates too; an all-ones side clamps to 256.
    script.push_back(config_row(CFG_SCALE_H, 65));
    script.push_back(config_row(CFG_SOURCE_SIDE, '1));
    script.push_back(query_row(63, 0, 1'b0, 0));

    @(posedge rst_ni);
    foreach (script[i]) begin
      if (script[i].kind == ROW_CONFIG) begin
        wait_drained();
        write_reg(script[i].idx, script[i].val);
        n_settings++;
      end else begin
        send_request(script[i].req, script[i].typed, script[i].want);
      end
    end

    // Random phases. The first few pin the register extremes; the rest draw
    // settings at random, mostly on small maps that can be loaded whole.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin h_val = 1;   v_val = 1;   side_val = 2;        end
        1: begin h_val = 64;  v_val = 255; side_val = SIDE_MAX; end
        2: begin h_val = 0;   v_val = 0;   side_val = 1;        end
        3: begin h_val = '1;  v_val = '1;  side_val = '1;       end
        4: begin h_val = 65;  v_val = 128; side_val = 3;        end
        default: begin
          h_val    = $urandom_range(0, 127);
          v_val    = $urandom_range(0, 255);
          side_val = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 511)
                                                 : $urandom_range(2, 8);
        end
      endcase
      // The last two phases run without any idling on either side.
      idle_on = (phase < PHASES - 2);
      wait_drained();
      write_reg(CFG_SCALE_H, h_val);
      write_reg(CFG_SCALE_V, v_val);
      write_reg(CFG_SOURCE_SIDE, side_val);
      n_settings++;
      load_window();
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // Output held off for a long stretch while requests keep coming.
        if (phase == 2 && k == 5) hold_off_pending = 1'b1;
        // Requests pause once until the block has answered everything.
        if (phase == 5 && k == 30) wait_drained();
        send_request(random_request(), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d loads and %0d queries over %0d register settings,",
             n_loads, n_queries, n_settings);
    $display("with random idling on both sides and one long output stall.");
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
